// File: design/mexp_pkg.sv
// Package for the modular exponentiation block: operand width, sequencer states,
// request/response structs of the shared modular multiplier and helper functions.
// No dependencies.
`default_nettype none
package mexp_pkg;

    // Operand width of the arithmetic (8..64) and width of the port fields
    localparam int WIDTH   = 32;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [FIELD_W-1:0] t_field;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    // Request to the shared multiplier: product a*b mod m, b scanned MSB first
    typedef struct packed {
        logic  go;
        t_word a;
        t_word b;
    } t_mm_req;

    // Response of the shared multiplier
    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mm_rsp;

    // (x + y) mod m for x, y < m
    function automatic t_word add_mod(input t_word x, input t_word y, input t_word m);
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    // Port field to operand width: zero-extend or keep the low bits
    function automatic t_word field_to_word(input t_field v);
        logic [63:0] t;
        t = 64'(v);
        return t[WIDTH-1:0];
    endfunction

    // Operand width to port field
    function automatic t_field word_to_field(input t_word v);
        logic [63:0] t;
        t = 64'(v);
        return t[FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: design/mexp_mulmod.sv
// Shared modular multiplier: shift-and-add, one multiplier bit per cycle.
// Depends on mexp_pkg.
`default_nettype none
module mexp_mulmod import mexp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_word   i_modulus,
    input  wire t_mm_req i_req,
    output t_mm_rsp      o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_word             r_acc, n_acc;
    t_word             r_a, n_a;
    t_word             r_b, n_b;
    t_word             dbl;

    // Double the accumulator, then add a when the current multiplier bit is set
    always_comb begin
        dbl    = add_mod(r_acc, r_acc, i_modulus);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_req.go) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WIDTH);
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
        end else if (r_busy) begin
            n_acc = r_b[WIDTH-1] ? add_mod(dbl, r_a, i_modulus) : dbl;
            n_b   = {r_b[WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule
`default_nettype wire

// File: design/mexp_seq.sv
// Sequencer of the exponentiation: base reduction, then right-to-left square
// and multiply through the shared multiplier; exponent zero skips both. Depends on mexp_pkg.
`default_nettype none
module mexp_seq import mexp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_word   i_modulus,
    input  wire logic    i_start,
    input  wire t_word   i_base,
    input  wire t_word   i_exp,
    input  wire t_mm_rsp i_rsp,
    output t_mm_req      o_req,
    output logic         o_busy,
    output logic         o_done,
    output t_word        o_result
);

    t_state r_state, n_state;
    t_word  r_res, n_res;
    t_word  r_base, n_base;
    t_word  r_exp, n_exp;
    logic   accept;
    logic   exp_last;

    assign accept   = i_start && (r_state == S_IDLE);
    assign exp_last = (r_exp[WIDTH-1:1] == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_exp == '0) ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_rsp.done) n_state = S_STEP;
            end
            S_STEP: begin
                n_state = r_exp[0] ? S_MUL : S_SQR;
            end
            S_MUL: begin
                if (i_rsp.done) n_state = exp_last ? S_DONE : S_SQR;
            end
            S_SQR: begin
                if (i_rsp.done) n_state = S_STEP;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Multiplier requests and status outputs
    always_comb begin
        o_req.go = 1'b0;
        o_req.a  = r_base;
        o_req.b  = r_base;
        o_busy   = (r_state != S_IDLE);
        o_done   = (r_state == S_DONE);
        case (r_state)
            S_IDLE: begin
                // 1 * base scanned bitwise leaves base mod m
                o_req.go = accept && (i_exp != '0);
                o_req.a  = WIDTH'(1);
                o_req.b  = i_base;
            end
            S_STEP: begin
                o_req.go = 1'b1;
                o_req.a  = r_exp[0] ? r_res : r_base;
            end
            S_MUL: begin
                o_req.go = i_rsp.done && !exp_last;
            end
            default: begin
                o_req.go = 1'b0;
            end
        endcase
    end

    // Running result, base power and remaining exponent
    always_comb begin
        n_res  = r_res;
        n_base = r_base;
        n_exp  = r_exp;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_exp = i_exp;
                    if (i_exp == '0 || i_modulus != WIDTH'(1)) begin
                        n_res = WIDTH'(1);
                    end else begin
                        n_res = '0;
                    end
                end
            end
            S_REDUCE: begin
                if (i_rsp.done) n_base = i_rsp.prod;
            end
            S_MUL: begin
                if (i_rsp.done) n_res = i_rsp.prod;
            end
            S_SQR: begin
                if (i_rsp.done) begin
                    n_base = i_rsp.prod;
                    n_exp  = {1'b0, r_exp[WIDTH-1:1]};
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_base <= n_base;
        r_exp  <= n_exp;
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

// File: design/modular_exponentiation.sv
// Top level of the modular exponentiation block: modulus register, sequencer
// and shared modular multiplier. Depends on mexp_pkg, mexp_seq, mexp_mulmod.
// Exponent zero gives its result in the cycle after the accepting edge. Otherwise the base
// is reduced first, then each exponent bit but the top one costs a square and each set bit
// a multiply, all through the one shift-and-add multiplier that works one bit per cycle.
// Busy drops in the cycle after the strobe, and a new beat is taken only once busy is low.
// Synchronous active-low reset returns to idle with modulus 1; o_done can't stall.
`default_nettype none
module modular_exponentiation import mexp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire t_field i_cfg_data,
    input  wire logic   start,
    input  wire t_field i_base_value,
    input  wire t_field i_exponent,
    output logic        busy,
    output logic        o_done,
    output t_field      o_power_result
);

    t_field  r_modulus;
    t_word   mod_w;
    t_word   mod_eff;
    t_mm_req req;
    t_mm_rsp rsp;
    t_word   result;

    // Hold the modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= FIELD_W'(1);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    // Treat a modulus of zero as one
    assign mod_w   = field_to_word(r_modulus);
    assign mod_eff = (mod_w == '0) ? WIDTH'(1) : mod_w;

    mexp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_modulus(mod_eff),
        .i_start  (start),
        .i_base   (field_to_word(i_base_value)),
        .i_exp    (field_to_word(i_exponent)),
        .i_rsp    (rsp),
        .o_req    (req),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (result)
    );

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_modulus(mod_eff),
        .i_req    (req),
        .o_rsp    (rsp)
    );

    assign o_power_result = word_to_field(result);

endmodule
`default_nettype wire

// File: design/mexp_checker.sv
// Port-level checker for the modular exponentiation block, bound to the top level.
// Depends on mexp_pkg.
`default_nettype none
module mexp_checker import mexp_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   start,
    input wire logic   busy,
    input wire logic   o_done,
    input wire t_field i_exponent,
    input wire t_field o_power_result
);

    // An accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepted beat");

    // A result shows only while the item is still held
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // The block frees up right after a result and never strobes twice
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("block not released after result");

    // Exponent zero answers one in the next cycle
    a_exp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_exponent == '0) |=> o_done && (o_power_result == FIELD_W'(1)))
        else $error("exponent zero did not give one");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .i_exponent    (i_exponent),
    .o_power_result(o_power_result)
);
`default_nettype wire

// File: tb/tb.sv
// Testbench for modular_exponentiation: drives base/exponent beats and modulus writes,
// predicts each power_result in-house and checks every o_done strobe against it.
// Depends on mexp_pkg and the modular_exponentiation RTL.
module tb import mexp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 6_000_000;
    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned TAIL_CYCLES   = 2200;
    localparam int unsigned PHASE_BEATS   = 42;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned IDLE_PERCENT  = 18;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_field i_cfg_data;
    logic   start;
    t_field i_base_value;
    t_field i_exponent;
    logic   busy;
    logic   o_done;
    t_field o_power_result;

    t_field      expected_powers[$];
    t_field      modulus_shadow;
    t_field      power_want;
    bit          sender_idles;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    modular_exponentiation u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .busy           (busy),
        .o_done         (o_done),
        .o_power_result (o_power_result)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Right-to-left square and multiply; a modulus of zero acts as one
    function automatic t_field predict_power(input t_field modv, input t_field base,
                                             input t_field ex);
        longint unsigned m;
        longint unsigned b;
        longint unsigned acc;
        t_field          e;
        m = modv;
        if (m == 0) m = 1;
        if (ex == 0) return t_field'(1);
        acc = 1 % m;
        b   = base % m;
        e   = ex;
        while (e != 0) begin
            if (e[0]) acc = (acc * b) % m;
            e = e >> 1;
            b = (b * b) % m;
        end
        return t_field'(acc);
    endfunction

    // Bias bases toward values around the modulus
    function automatic t_field pick_base();
        case ($urandom_range(9))
            0: return '0;
            1: return t_field'(1);
            2: return modulus_shadow - t_field'(1);
            3: return modulus_shadow;
            4: return '1;
            default: return t_field'($urandom);
        endcase
    endfunction

    // Mix short, partial-length and full-length exponents to bound run time
    function automatic t_field pick_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return t_field'($urandom_range(1, 255));
            5, 6: return t_field'($urandom) >> $urandom_range(0, 31);
            default: return t_field'($urandom);
        endcase
    endfunction

    // Send one beat, with an occasional gap ahead of it; push its prediction on acceptance
    task automatic send_power_beat(input t_field base, input t_field ex);
        int unsigned gap;
        if (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
            gap = ($urandom_range(2) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 2200);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_base_value <= base;
        i_exponent   <= ex;
        do @(posedge i_clk); while (busy);
        expected_powers.push_back(predict_power(modulus_shadow, base, ex));
    endtask

    // Hold off the sender until every expected result is back and the block is idle
    task automatic drain_results();
        start <= 1'b0;
        while (expected_powers.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_modulus(input t_field value);
        drain_results();
        @(posedge i_clk);
        i_cfg_we       <= 1'b1;
        i_cfg_data     <= value;
        modulus_shadow  = value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
    endtask

    // Zero exponent gives one with modulus one and zero; nonzero exponents run beside it
    task automatic test_zero_exponent();
        send_power_beat(32'd5, 32'd0);
        send_power_beat(32'd5, 32'd3);
        write_modulus(32'd0);
        send_power_beat(32'hFFFF_FFFF, 32'd0);
        send_power_beat(32'd7, 32'd7);
        write_modulus(32'd1);
        send_power_beat('1, '1);
    endtask

    // Extremes of base and exponent with the largest modulus
    task automatic test_field_extremes();
        write_modulus(32'hFFFF_FFFF);
        send_power_beat('1, '1);
        send_power_beat(32'hFFFF_FFFE, '1);
        send_power_beat(32'd0, 32'd1);
        send_power_beat(32'd0, 32'd0);
        send_power_beat(32'd1, '1);
        send_power_beat(32'd2, 32'd31);
        send_power_beat(32'h8000_0000, 32'h8000_0000);
    endtask

    // Bases at and above the modulus are reduced first
    task automatic test_base_reduction();
        write_modulus(32'hFFFF_FFFB);
        send_power_beat(32'hFFFF_FFFF, 32'd2);
        send_power_beat(32'hFFFF_FFFB, 32'd5);
        send_power_beat(32'hFFFF_FFFC, '1);
        write_modulus(32'd2);
        send_power_beat(32'd3, 32'd9);
        send_power_beat(32'd4, 32'd1);
    endtask

    // Textbook key pair: encrypt then decrypt, then a large public exponent
    task automatic test_rsa_pairs();
        write_modulus(32'd3233);
        send_power_beat(32'd65, 32'd17);
        send_power_beat(32'd2790, 32'd2753);
        send_power_beat(32'd3232, 32'd65537);
    endtask

    // Random beats over several moduli; one phase runs without any gaps
    task automatic test_random_powers();
        t_field mod_choice;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: mod_choice = '1;
                1: mod_choice = t_field'($urandom) | 32'h8000_0000;
                2: mod_choice = t_field'($urandom_range(2, 1000));
                3: mod_choice = 32'h8000_0000;
                4: mod_choice = t_field'($urandom_range(1, 32'hFFFF_FFFF));
                default: mod_choice = t_field'($urandom_range(1, 65535));
            endcase
            write_modulus(mod_choice);
            sender_idles = (phase != 3);
            for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
                send_power_beat(pick_base(), pick_exponent());
            end
        end
        sender_idles = 1'b1;
    endtask

    // Compare every strobed result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_power_result);
                mismatch_count++;
            end else begin
                power_want = expected_powers.pop_front();
                if (o_power_result !== power_want || o_done !== 1'b1) begin
                    $display("%0t: power_result mismatch, expected %h, actual %h",
                             $time, power_want, o_power_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modular_exponentiation test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= '0;
        start          <= 1'b0;
        i_base_value   <= '0;
        i_exponent     <= '0;
        modulus_shadow  = t_field'(1);
        sender_idles    = 1'b1;
        mismatch_count  = 0;
        cycle_count     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_exponent();
        test_field_extremes();
        test_base_reduction();
        test_rsa_pairs();
        test_random_powers();

        // Let any stray strobe show up before the verdict
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_powers.size() == 0) begin
            $display("modular_exponentiation test passed");
        end else begin
            $display("modular_exponentiation test failed");
        end
        $finish;
    end

endmodule
